[sv/trz_pkg.sv]
// Package for the triangle rasterizer with depth buffer.
// Item codes, command/status structs and fixed field widths. No dependencies.
`default_nettype none
package trz_pkg;

  localparam int FRAC_BITS  = 4;
  localparam int DEPTH_BITS = 16;
  localparam int COORD_W    = 12;
  localparam int COLOR_W    = 24;
  localparam int CFG_W      = 9;
  localparam int PIX_W      = 8;
  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;

  typedef enum logic [1:0] {
    FUNC_LOAD  = 2'd0,
    FUNC_STEP  = 2'd1,
    FUNC_CLEAR = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_RSV2   = 2'd2,
    CFG_RSV3   = 2'd3
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SETUP,
    ST_EMUL,
    ST_ESUB,
    ST_WMUL,
    ST_NUMSUM,
    ST_DIV,
    ST_DCMP,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic accept;
    logic setup;
    logic edge_mul;
    logic edge_sub;
    logic wmul;
    logic numsum;
    logic div_step;
    logic dcmp;
    logic emit;
    logic clr_step;
  } cmd_t;

  typedef struct packed {
    func_t item_func;
    logic  active;
    logic  in_tri;
    logic  div_last;
    logic  clr_last;
    logic  out_busy;
  } stat_t;

endpackage
`default_nettype wire

[sv/trz_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module trz_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 65536
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[sv/trz_ctrl.sv]
// Controller state machine of the rasterizer.
// Uses trz_pkg; drives commands to trz_dp and reads its status.
`default_nettype none
module trz_ctrl
  import trz_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  input  wire logic  [1:0] in_func,
  output logic       in_stall,
  input  wire stat_t stat,
  output cmd_t       cmd
);
  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = (state_r != ST_IDLE);
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          priority if (func_t'(in_func) == FUNC_LOAD) state_nxt = ST_SETUP;
          else if (func_t'(in_func) == FUNC_STEP && stat.active) state_nxt = ST_EMUL;
          else state_nxt = ST_EMIT;
        end
      end
      ST_SETUP: begin
        cmd.setup = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMUL: begin
        cmd.edge_mul = 1'b1;
        state_nxt = ST_ESUB;
      end
      ST_ESUB: begin
        cmd.edge_sub = 1'b1;
        state_nxt = ST_WMUL;
      end
      ST_WMUL: begin
        cmd.wmul = 1'b1;
        state_nxt = stat.in_tri ? ST_NUMSUM : ST_EMIT;
      end
      ST_NUMSUM: begin
        cmd.numsum = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) state_nxt = ST_DCMP;
      end
      ST_DCMP: begin
        cmd.dcmp = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (!stat.out_busy) begin
          cmd.emit = 1'b1;
          state_nxt = (stat.item_func == FUNC_CLEAR) ? ST_CLEAR : ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

[sv/trz_dp.sv]
// Datapath of the rasterizer: vertex store, box setup, edge functions,
// serial depth divider, depth RAM and output register. Uses trz_pkg, trz_ram.
`default_nettype none
module trz_dp
  import trz_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire cmd_t                  cmd,
  output stat_t                      stat,
  input  wire logic                  cfg_valid,
  input  wire logic [1:0]            cfg_index,
  input  wire logic [CFG_W-1:0]      cfg_data,
  input  wire logic [1:0]            in_func,
  input  wire logic [1:0]            in_vertex_slot,
  input  wire logic [COORD_W-1:0]    in_vert_x,
  input  wire logic [COORD_W-1:0]    in_vert_y,
  input  wire logic [DEPTH_BITS-1:0] in_vert_z,
  input  wire logic [COLOR_W-1:0]    in_tri_color,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [PIX_W-1:0]           out_pixel_x,
  output logic [PIX_W-1:0]           out_pixel_y,
  output logic                       out_write_pixel,
  output logic [COLOR_W-1:0]         out_pixel_color,
  output logic [DEPTH_BITS-1:0]      out_pixel_depth,
  output logic                       out_box_done
);
  localparam int MAXD  = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int AXW   = $clog2(MAXD);
  localparam int LOW_W = COORD_W - FRAC_BITS;
  localparam int BW    = ((AXW > LOW_W) ? AXW : LOW_W) + 2;
  localparam int PCW   = AXW + 1 + FRAC_BITS;
  localparam int VW    = COORD_W + 1;
  localparam int DW    = ((PCW > VW) ? PCW : VW) + 1;
  localparam int MW    = 2 * DW;
  localparam int EW    = MW + 1;
  localparam int AW    = EW + 2;
  localparam int NUMW  = EW + DEPTH_BITS + 2;
  localparam int RDEP  = MAX_WIDTH * MAX_HEIGHT;
  localparam int RAW   = $clog2(RDEP);
  localparam int DCW   = $clog2(DEPTH_BITS);
  localparam logic [DEPTH_BITS-1:0] FAR = '1;

  logic [CFG_W-1:0] scr_w_r, scr_h_r;
  logic [COORD_W-1:0] vx_r [3];
  logic [COORD_W-1:0] vy_r [3];
  logic [DEPTH_BITS-1:0] vz_r [3];
  logic [COLOR_W-1:0] color_r;
  func_t func_r;
  logic [BW-1:0] x0_r, x1_r, y0_r, y1_r, sx_r, sy_r;
  logic active_r;
  logic signed [MW-1:0] ma_r [3];
  logic signed [MW-1:0] mb_r [3];
  logic signed [EW-1:0] e_r [3];
  logic [NUMW-1:0] p_r [3];
  logic [AW-1:0] area_r;
  logic [NUMW-1:0] rem_r, div_r;
  logic [DEPTH_BITS-1:0] q_r;
  logic [DCW-1:0] dcnt_r;
  logic pass_r;
  logic [RAW-1:0] ccnt_r;
  logic [DEPTH_BITS-1:0] rdata;

  // Config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scr_w_r <= CFG_W'(256);
      scr_h_r <= CFG_W'(256);
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_WIDTH:  scr_w_r <= cfg_data;
        CFG_HEIGHT: scr_h_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Box setup
  function automatic logic [COORD_W-1:0] min3(input logic [COORD_W-1:0] a, b, c);
    logic [COORD_W-1:0] m;
    m = (b < a) ? b : a;
    return (c < m) ? c : m;
  endfunction
  function automatic logic [COORD_W-1:0] max3(input logic [COORD_W-1:0] a, b, c);
    logic [COORD_W-1:0] m;
    m = (b > a) ? b : a;
    return (c > m) ? c : m;
  endfunction
  function automatic logic [BW-1:0] lim_of(input logic [CFG_W-1:0] v, input int mx);
    logic [BW-1:0] ve;
    ve = BW'(v);
    if (v == '0) return BW'(1);
    return (ve > BW'(mx)) ? BW'(mx) : ve;
  endfunction

  logic [BW-1:0] lo_x, hi_x, lo_y, hi_y, lim_x, lim_y;
  logic [COORD_W:0] hx_sum, hy_sum;
  always_comb begin
    lim_x  = lim_of(scr_w_r, MAX_WIDTH);
    lim_y  = lim_of(scr_h_r, MAX_HEIGHT);
    lo_x   = BW'(min3(vx_r[0], vx_r[1], vx_r[2]) >> FRAC_BITS);
    lo_y   = BW'(min3(vy_r[0], vy_r[1], vy_r[2]) >> FRAC_BITS);
    hx_sum = (COORD_W+1)'(max3(vx_r[0], vx_r[1], vx_r[2]))
           + (COORD_W+1)'((1 << FRAC_BITS) - 1);
    hy_sum = (COORD_W+1)'(max3(vy_r[0], vy_r[1], vy_r[2]))
           + (COORD_W+1)'((1 << FRAC_BITS) - 1);
    hi_x   = BW'(hx_sum >> FRAC_BITS);
    hi_y   = BW'(hy_sum >> FRAC_BITS);
    if (hi_x > lim_x) hi_x = lim_x;
    if (hi_y > lim_y) hi_y = lim_y;
  end

  // Edge operands
  logic signed [DW-1:0] px, py;
  logic signed [DW-1:0] vxs [3];
  logic signed [DW-1:0] vys [3];
  always_comb begin
    px = DW'({sx_r[AXW-1:0], 1'b1} << FRAC_BITS);
    py = DW'({sy_r[AXW-1:0], 1'b1} << FRAC_BITS);
    for (int i = 0; i < 3; i++) begin
      vxs[i] = DW'({vx_r[i], 1'b0});
      vys[i] = DW'({vy_r[i], 1'b0});
    end
  end

  // Scan advance
  logic [BW-1:0] ny, nx;
  assign ny = sy_r + BW'(1);
  assign nx = sx_r + BW'(1);

  logic [NUMW-1:0] num_sum;
  assign num_sum = p_r[0] + p_r[1] + p_r[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        vx_r[i] <= '0;
        vy_r[i] <= '0;
        vz_r[i] <= '0;
      end
      color_r  <= '0;
      func_r   <= FUNC_NONE;
      x0_r     <= '0;
      x1_r     <= '0;
      y0_r     <= '0;
      y1_r     <= '0;
      sx_r     <= '0;
      sy_r     <= '0;
      active_r <= 1'b0;
      pass_r   <= 1'b0;
      dcnt_r   <= '0;
      ccnt_r   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.emit) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      if (cmd.accept) begin
        func_r <= func_t'(in_func);
        pass_r <= 1'b0;
        if (func_t'(in_func) == FUNC_LOAD && in_vertex_slot != 2'd3) begin
          vx_r[in_vertex_slot] <= in_vert_x;
          vy_r[in_vertex_slot] <= in_vert_y;
          vz_r[in_vertex_slot] <= in_vert_z;
          if (in_vertex_slot == 2'd0) color_r <= in_tri_color;
        end
      end
      if (cmd.setup) begin
        x0_r     <= lo_x;
        x1_r     <= hi_x;
        y0_r     <= lo_y;
        y1_r     <= hi_y;
        sx_r     <= lo_x;
        sy_r     <= lo_y;
        active_r <= (lo_x < hi_x) && (lo_y < hi_y);
      end
      if (cmd.numsum) dcnt_r <= '0;
      if (cmd.div_step) dcnt_r <= dcnt_r + DCW'(1);
      if (cmd.dcmp && rdata >= q_r) pass_r <= 1'b1;
      if (cmd.clr_step) ccnt_r <= (ccnt_r == RAW'(RDEP - 1)) ? '0 : ccnt_r + RAW'(1);
      if (cmd.emit) begin
        if (func_r == FUNC_STEP && active_r) begin
          if (ny >= y1_r) begin
            sy_r <= y0_r;
            sx_r <= nx;
            if (nx >= x1_r) active_r <= 1'b0;
          end else begin
            sy_r <= ny;
          end
        end
      end
    end
  end

  // Arithmetic pipeline, payload only
  always_ff @(posedge clk) begin
    if (cmd.edge_mul) begin
      for (int i = 0; i < 3; i++) begin
        ma_r[i] <= (vxs[(i+1)%3] - vxs[i]) * (py - vys[i]);
        mb_r[i] <= (vys[(i+1)%3] - vys[i]) * (px - vxs[i]);
      end
    end
    if (cmd.edge_sub) begin
      for (int i = 0; i < 3; i++) begin
        e_r[i] <= EW'(ma_r[i]) - EW'(mb_r[i]);
      end
    end
    if (cmd.wmul) begin
      for (int i = 0; i < 3; i++) begin
        p_r[i] <= NUMW'(e_r[i][EW-2:0] * vz_r[(i+2)%3]);
      end
      area_r <= AW'(e_r[0][EW-2:0]) + AW'(e_r[1][EW-2:0]) + AW'(e_r[2][EW-2:0]);
    end
    if (cmd.numsum) begin
      rem_r <= num_sum;
      div_r <= NUMW'(area_r) << (DEPTH_BITS - 1);
    end
    if (cmd.div_step) begin
      if (rem_r >= div_r) begin
        rem_r <= rem_r - div_r;
      end
      q_r   <= {q_r[DEPTH_BITS-2:0], rem_r >= div_r};
      div_r <= div_r >> 1;
    end
    if (cmd.emit) begin
      if (func_r == FUNC_STEP && active_r) begin
        out_pixel_x     <= sx_r[PIX_W-1:0];
        out_pixel_y     <= sy_r[PIX_W-1:0];
        out_write_pixel <= pass_r;
        out_pixel_color <= pass_r ? color_r : '0;
        out_pixel_depth <= pass_r ? q_r : '0;
        out_box_done    <= (ny >= y1_r) && (nx >= x1_r);
      end else begin
        out_pixel_x     <= '0;
        out_pixel_y     <= '0;
        out_write_pixel <= 1'b0;
        out_pixel_color <= '0;
        out_pixel_depth <= '0;
        out_box_done    <= (func_r == FUNC_STEP);
      end
    end
  end

  // Depth RAM
  logic [RAW-1:0] pix_addr;
  logic ram_we;
  logic [RAW-1:0] ram_waddr;
  logic [DEPTH_BITS-1:0] ram_wdata;
  assign pix_addr  = RAW'(sy_r * MAX_WIDTH) + RAW'(sx_r);
  assign ram_we    = cmd.clr_step || (cmd.dcmp && rdata >= q_r);
  assign ram_waddr = cmd.clr_step ? ccnt_r : pix_addr;
  assign ram_wdata = cmd.clr_step ? FAR : q_r;

  trz_ram #(.WIDTH(DEPTH_BITS), .DEPTH(RDEP)) u_zram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (pix_addr),
    .rdata (rdata)
  );

  always_comb begin
    stat.item_func = func_r;
    stat.active    = active_r;
    stat.in_tri    = (e_r[0] > 0) && (e_r[1] > 0) && (e_r[2] > 0);
    stat.div_last  = (dcnt_r == DCW'(DEPTH_BITS - 1));
    stat.clr_last  = (ccnt_r == RAW'(RDEP - 1));
    stat.out_busy  = out_valid && out_stall;
  end
endmodule
`default_nettype wire

[sv/triangle_raster_zbuffer_top.sv]
// Top level of the edge-function triangle rasterizer with depth buffer.
// Joins trz_ctrl and trz_dp; uses trz_pkg.
//
// Input items (in_valid/in_stall) load a vertex, step one pixel of the
// triangle's bounding box, or clear the depth buffer. Each item yields one
// result transfer on out_valid/out_stall. The cfg_ channel writes screen
// width (index 0) and height (index 1); cfg_ready is always high.
// A load item runs box setup; a step in an active box forms the edge
// products, edge functions and depth weights, and a step inside the
// triangle then sums them, runs the bit-serial depth divider and the depth
// compare, all before the result register. One item is in flight at a
// time; the next is taken only in the idle state, after the last is emitted.
// Reset and each clear item run a sweep writing far depth to every entry of
// the depth RAM, with in_stall high.
// If the receiver stalls, a finished result waits in the output register;
// a further item may be taken and processed but its result holds until the
// register frees.
`default_nettype none
module triangle_raster_zbuffer_top
  import trz_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [1:0]            cfg_index,
  input  wire logic [CFG_W-1:0]      cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [1:0]            in_func,
  input  wire logic [1:0]            in_vertex_slot,
  input  wire logic [COORD_W-1:0]    in_vert_x,
  input  wire logic [COORD_W-1:0]    in_vert_y,
  input  wire logic [DEPTH_BITS-1:0] in_vert_z,
  input  wire logic [COLOR_W-1:0]    in_tri_color,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [PIX_W-1:0]           out_pixel_x,
  output logic [PIX_W-1:0]           out_pixel_y,
  output logic                       out_write_pixel,
  output logic [COLOR_W-1:0]         out_pixel_color,
  output logic [DEPTH_BITS-1:0]      out_pixel_depth,
  output logic                       out_box_done
);
  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  trz_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_func  (in_func),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  trz_dp #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .cfg_valid       (cfg_valid),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_func         (in_func),
    .in_vertex_slot  (in_vertex_slot),
    .in_vert_x       (in_vert_x),
    .in_vert_y       (in_vert_y),
    .in_vert_z       (in_vert_z),
    .in_tri_color    (in_tri_color),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_pixel_x     (out_pixel_x),
    .out_pixel_y     (out_pixel_y),
    .out_write_pixel (out_write_pixel),
    .out_pixel_color (out_pixel_color),
    .out_pixel_depth (out_pixel_depth),
    .out_box_done    (out_box_done)
  );
endmodule
`default_nettype wire
